// ----- hw/rtl/bounded_lifo_stack_core_macros.svh -----
// assertion macros shared by the stack rtl
`ifndef BOUNDED_LIFO_STACK_CORE_MACROS_SVH
`define BOUNDED_LIFO_STACK_CORE_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define BLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bls_pkg.sv -----
`timescale 1ns / 1ps

package bls_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int FILL_W        = 7;
    localparam int IDX_W         = 6;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_LIST = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
        logic rotate;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/bls_if.sv -----
`timescale 1ns / 1ps

interface bls_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         req_type;
    logic signed [bls_pkg::WORD_W-1:0]  push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface bls_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic signed [bls_pkg::WORD_W-1:0]  data_value;
    logic [bls_pkg::IDX_W-1:0]          entry_index;
    logic                               last_flag;

    modport source (output valid, output status, output data_value,
                    output entry_index, output last_flag, input ready);
    modport sink   (input valid, input status, input data_value,
                    input entry_index, input last_flag, output ready);
endinterface

// ----- hw/rtl/bls_cell.sv -----
`timescale 1ns / 1ps

module bls_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bls_pkg::t_cell_ctl                i_ctl,
    input  logic signed [bls_pkg::WORD_W-1:0] i_above_data,
    input  logic                              i_above_valid,
    input  logic signed [bls_pkg::WORD_W-1:0] i_below_data,
    input  logic                              i_below_valid,
    input  logic signed [bls_pkg::WORD_W-1:0] i_top_data,
    output logic signed [bls_pkg::WORD_W-1:0] o_data,
    output logic                              o_valid
);

    logic signed [bls_pkg::WORD_W-1:0] r_data, n_data;
    logic                              r_valid, n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.push) begin
            n_data  = i_above_data;
            n_valid = i_above_valid;
        end else if (i_ctl.pop) begin
            n_data  = i_below_data;
            n_valid = i_below_valid;
        end else if (i_ctl.rotate && r_valid) begin
            // the deepest filled cell wraps around to the old top
            n_data = i_below_valid ? i_below_data : i_top_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

// ----- hw/rtl/bounded_lifo_stack_core.sv -----
`timescale 1ns / 1ps
// bounded lifo stack of signed 32-bit words, up to DEPTH entries
// request channel i_req carries req_type (push, pop, list) and push_value;
// response channel o_rsp returns status, data_value, entry_index, last_flag.
// push and pop give one result each, registered and shown in the cycle
// after the item is taken, and a new push or pop can be taken every cycle
// while the response register is free or being drained in the same cycle.
// list on a non-empty stack enters the listing state, then gives one
// entry per cycle while o_rsp is free, top first; the stack rotates
// through its row of cells so each entry reaches the top cell in turn,
// and i_req.ready stays low meanwhile. list on an empty stack, and push
// full or pop empty, return a single error result. req_type 3 is dropped
// with no result. a stalled o_rsp holds its item and backpressures i_req
// (or the listing). synchronous active-low reset empties the stack and drops
// any pending result; stored words are not cleared.
`include "bounded_lifo_stack_core_macros.svh"

module bounded_lifo_stack_core #(
    parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bls_req_if.sink   i_req,
    bls_rsp_if.source o_rsp
);

    bls_pkg::t_state    r_state, n_state;
    logic [bls_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [bls_pkg::IDX_W-1:0]  r_list_idx, n_list_idx;

    logic                              r_out_valid, n_out_valid;
    logic [1:0]                        r_status, n_status;
    logic signed [bls_pkg::WORD_W-1:0] r_data, n_data;
    logic [bls_pkg::IDX_W-1:0]         r_index, n_index;
    logic                              r_last, n_last;

    bls_pkg::t_cell_ctl                w_ctl;
    logic signed [bls_pkg::WORD_W-1:0] w_data  [DEPTH];
    logic                              w_valid [DEPTH];

    logic w_out_free;
    logic w_accept;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == bls_pkg::ST_IDLE) && w_out_free;
    assign w_accept = i_req.valid && i_req.ready;

    // cell 0 is the top of the stack
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        bls_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_above_data  ((gi == 0) ? i_req.push_value : w_data[(gi == 0) ? 0 : gi - 1]),
            .i_above_valid ((gi == 0) ? 1'b1 : w_valid[(gi == 0) ? 0 : gi - 1]),
            .i_below_data  ((gi == DEPTH - 1) ? '0
                            : w_data[(gi == DEPTH - 1) ? gi : gi + 1]),
            .i_below_valid ((gi == DEPTH - 1) ? 1'b0
                            : w_valid[(gi == DEPTH - 1) ? gi : gi + 1]),
            .i_top_data    (w_data[0]),
            .o_data        (w_data[gi]),
            .o_valid       (w_valid[gi])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_list_idx  = r_list_idx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_data      = r_data;
        n_index     = r_index;
        n_last      = r_last;
        w_ctl       = '0;

        unique case (r_state)
            bls_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.req_type)
                        bls_pkg::REQ_PUSH: begin
                            n_out_valid = 1'b1;
                            n_data      = '0;
                            n_index     = '0;
                            n_last      = 1'b1;
                            if (r_fill == bls_pkg::FILL_W'(DEPTH)) begin
                                n_status = bls_pkg::STATUS_FULL;
                            end else begin
                                n_status  = bls_pkg::STATUS_OK;
                                w_ctl.push = 1'b1;
                                n_fill    = r_fill + 1'b1;
                            end
                        end
                        bls_pkg::REQ_POP: begin
                            n_out_valid = 1'b1;
                            n_last      = 1'b1;
                            if (r_fill == '0) begin
                                n_status = bls_pkg::STATUS_EMPTY;
                                n_data   = '0;
                                n_index  = '0;
                            end else begin
                                n_status  = bls_pkg::STATUS_OK;
                                n_data    = w_data[0];
                                n_index   = bls_pkg::IDX_W'(r_fill - 1'b1);
                                w_ctl.pop = 1'b1;
                                n_fill    = r_fill - 1'b1;
                            end
                        end
                        bls_pkg::REQ_LIST: begin
                            if (r_fill == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = bls_pkg::STATUS_EMPTY;
                                n_data      = '0;
                                n_index     = '0;
                                n_last      = 1'b1;
                            end else begin
                                n_state    = bls_pkg::ST_LIST;
                                n_list_idx = bls_pkg::IDX_W'(r_fill - 1'b1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bls_pkg::ST_LIST: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_status     = bls_pkg::STATUS_OK;
                    n_data       = w_data[0];
                    n_index      = r_list_idx;
                    n_last       = (r_list_idx == '0);
                    w_ctl.rotate = 1'b1;
                    if (r_list_idx == '0) begin
                        n_state = bls_pkg::ST_IDLE;
                    end else begin
                        n_list_idx = r_list_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = bls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bls_pkg::ST_IDLE;
            r_fill      <= '0;
            r_list_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_list_idx  <= n_list_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_index  <= n_index;
        r_last   <= n_last;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.data_value  = r_data;
    assign o_rsp.entry_index = r_index;
    assign o_rsp.last_flag   = r_last;

    `BLS_ASSERT_NOW(a_fill_bounded, 1'b1, r_fill <= bls_pkg::FILL_W'(DEPTH),
        "fill count above depth")
    `BLS_ASSERT_NOW(a_top_valid_matches_fill, 1'b1, w_valid[0] == (r_fill != '0),
        "top cell valid disagrees with fill count")
    `BLS_ASSERT_NEXT(a_push_grows,
        w_accept && i_req.req_type == bls_pkg::REQ_PUSH
            && r_fill != bls_pkg::FILL_W'(DEPTH),
        r_fill == $past(r_fill) + 1'b1, "accepted push did not grow the stack")
    `BLS_ASSERT_NOW(a_list_idx_in_range, r_state == bls_pkg::ST_LIST,
        {1'b0, r_list_idx} < r_fill, "list index beyond filled cells")

endmodule
